>>> rtl/core/triangle_element_stiffness_core_defines.svh
// Assertion helpers for the core files, used by the back end (tesc_back).
`ifndef TRIANGLE_ELEMENT_STIFFNESS_CORE_DEFINES_SVH
`define TRIANGLE_ELEMENT_STIFFNESS_CORE_DEFINES_SVH

// same-cycle implication
`define TESC_ASSERT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tesc check failed");

// next-cycle implication
`define TESC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tesc check failed");

`endif

>>> rtl/core/tesc_pkg.sv
package tesc_pkg;

  localparam int OP_W   = 34;
  localparam int PROD_W = 2 * OP_W;
  localparam int DET_W  = PROD_W + 1;
  localparam int DEN_W  = DET_W + 1;
  localparam int FRAC_W = 32;
  localparam int NUM_W  = DET_W + FRAC_W;
  localparam int RES_W  = 64;
  localparam int QUEUE_DEPTH = 2;
  localparam logic [1:0] LOAD_COL = 2'd3;
  localparam logic [1:0] NO_ROW   = 2'd3;

  // division by six: base 2^16 long division, reciprocal per digit
  localparam int DIV6_CHUNK   = 16;
  localparam int DIV6_STEPS   = 5;
  localparam int DIV6_SPAN    = DIV6_CHUNK * DIV6_STEPS;
  localparam int DIV6_W       = DIV6_CHUNK + 3;
  localparam int DIV6_SHIFT   = 22;
  localparam int DIV6_RECIP_W = 20;
  localparam logic [DIV6_RECIP_W-1:0] DIV6_RECIP = 20'd699051;
  localparam logic [DIV6_W-1:0]       DIV6_DEN   = 19'd6;

  typedef struct packed {
    logic signed [31:0] x_a;
    logic signed [31:0] y_a;
    logic signed [31:0] x_b;
    logic signed [31:0] y_b;
    logic signed [31:0] x_c;
    logic signed [31:0] y_c;
    logic [15:0]        node_a;
    logic [15:0]        node_b;
    logic [15:0]        node_c;
  } tri_item_t;

  typedef struct packed {
    logic [15:0]        row_node;
    logic signed [63:0] entry_col_a;
    logic signed [63:0] entry_col_b;
    logic signed [63:0] entry_col_c;
    logic signed [63:0] load_part;
    logic               degenerate;
    logic               last;
  } row_item_t;

  // classified triangle handed from front to back
  typedef struct packed {
    logic [2:0][OP_W-1:0] p;
    logic [2:0][OP_W-1:0] q;
    logic [OP_W-1:0]      sx;
    logic [OP_W-1:0]      sy;
    logic [2:0][15:0]     node;
    logic [2:0]           emit;
  } tri_entry_t;

  typedef struct packed {
    logic                 start;
    logic [NUM_W-1:0]     num_mag;
    logic [DEN_W-1:0]     den_mag;
    logic                 neg;
    logic                 by6;
  } div_req_t;

  typedef enum logic [3:0] {
    B_IDLE, B_DET0, B_DET1, B_DETCHK, B_SEL,
    B_MULP, B_MULQ, B_DIVGO, B_DIVWAIT, B_EMIT
  } back_state_t;

endpackage

>>> rtl/core/triangle_element_stiffness_core.sv
// Each row runs three 101-step divisions by twice the determinant and a 5-step
// division by six for the load term. Throughput is set by the single shared
// divider in the back end; a two-entry queue lets the front accept while the
// back works. Reset (rst, synchronous) empties the queue and clears row_valid
// and the back-end state machine.
module triangle_element_stiffness_core import tesc_pkg::*; #(
  parameter int NODE_COUNT = 65536
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      tri_valid,
  output logic      tri_ready,
  input  tri_item_t tri_item,
  output logic      row_valid,
  input  logic      row_ready,
  output row_item_t row_item
);

  tri_entry_t front_entry, q_entry;
  logic q_full, q_avail, q_pop;

  assign tri_ready = !q_full;

  tesc_front #(.NODE_COUNT(NODE_COUNT)) u_front (
    .tri_item (tri_item),
    .entry    (front_entry)
  );

  tesc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (tri_valid && tri_ready),
    .push_data (front_entry),
    .full      (q_full),
    .pop       (q_pop),
    .avail     (q_avail),
    .pop_data  (q_entry)
  );

  tesc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .avail     (q_avail),
    .entry     (q_entry),
    .pop       (q_pop),
    .row_valid (row_valid),
    .row_ready (row_ready),
    .row_item  (row_item)
  );

endmodule

>>> rtl/core/tesc_front.sv
module tesc_front import tesc_pkg::*; #(
  parameter int NODE_COUNT = 65536
) (
  input  tri_item_t  tri_item,
  output tri_entry_t entry
);

  logic signed [OP_W-1:0] xa, ya, xb, yb, xc, yc;
  logic [2:0][15:0] nodes;

  always_comb begin
    xa = OP_W'(tri_item.x_a);
    ya = OP_W'(tri_item.y_a);
    xb = OP_W'(tri_item.x_b);
    yb = OP_W'(tri_item.y_b);
    xc = OP_W'(tri_item.x_c);
    yc = OP_W'(tri_item.y_c);
    nodes = {tri_item.node_c, tri_item.node_b, tri_item.node_a};
    entry.p[0] = yb - yc;
    entry.q[0] = xc - xb;
    entry.p[1] = yc - ya;
    entry.q[1] = xa - xc;
    entry.p[2] = ya - yb;
    entry.q[2] = xb - xa;
    entry.sx = xa + xb + xc;
    entry.sy = ya + yb + yc;
    entry.node = nodes;
    for (int i = 0; i < 3; i++) begin
      entry.emit[i] = (nodes[i] != '0) && ({16'b0, nodes[i]} < 32'(NODE_COUNT));
    end
  end

endmodule

>>> rtl/core/tesc_queue.sv
module tesc_queue import tesc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  tri_entry_t push_data,
  output logic       full,
  input  logic       pop,
  output logic       avail,
  output tri_entry_t pop_data
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  tri_entry_t mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [PTR_W:0]   count;

  assign full     = (count == (PTR_W+1)'(QUEUE_DEPTH));
  assign avail    = (count != '0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
    end
  end

endmodule

>>> rtl/core/tesc_div.sv
module tesc_div import tesc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  div_req_t         req,
  output logic             done,
  output logic [RES_W-1:0] quo
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] n;
  logic [DEN_W:0]   rem;
  logic [DEN_W-1:0] den;
  logic             neg;
  logic             by6;
  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W:0]   rem_sh;
  logic             fits;
  logic             pos_ovf, neg_ovf;
  logic [DIV6_W-1:0]              v6;
  logic [DIV6_W+DIV6_RECIP_W-1:0] v6_prod;
  logic [DIV6_CHUNK-1:0]          q6;
  logic [2:0]                     r6;

  always_comb begin
    rem_sh  = {rem[DEN_W-1:0], n[NUM_W-1]};
    fits    = rem_sh >= {1'b0, den};
    v6      = {rem[2:0], n[NUM_W-1 -: DIV6_CHUNK]};
    v6_prod = (DIV6_W+DIV6_RECIP_W)'(v6) * (DIV6_W+DIV6_RECIP_W)'(DIV6_RECIP);
    q6      = v6_prod[DIV6_SHIFT +: DIV6_CHUNK];
    r6      = 3'(v6 - DIV6_W'(q6) * DIV6_DEN);
    pos_ovf = (|n[NUM_W-1:RES_W-1]);
    neg_ovf = (|n[NUM_W-1:RES_W]) || (n[RES_W-1] && (|n[RES_W-2:0]));
    if (neg) begin
      quo = neg_ovf ? {1'b1, {(RES_W-1){1'b0}}} : (RES_W'(0) - n[RES_W-1:0]);
    end else begin
      quo = pos_ovf ? {1'b0, {(RES_W-1){1'b1}}} : n[RES_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      if (req.by6) begin
        n <= {req.num_mag[DIV6_SPAN-1:0], {(NUM_W-DIV6_SPAN){1'b0}}};
      end else begin
        n <= req.num_mag;
      end
      den <= req.den_mag;
      neg <= req.neg;
      by6 <= req.by6;
      rem <= '0;
    end else if (busy) begin
      if (by6) begin
        n   <= {n[NUM_W-DIV6_CHUNK-1:0], q6};
        rem <= (DEN_W+1)'(r6);
      end else begin
        n   <= {n[NUM_W-2:0], fits};
        rem <= fits ? rem_sh - {1'b0, den} : rem_sh;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == CNT_W'(1));
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.by6 ? CNT_W'(DIV6_STEPS) : CNT_W'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) busy <= 1'b0;
      end
    end
  end

endmodule

>>> rtl/core/tesc_back.sv
module tesc_back import tesc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       avail,
  input  tri_entry_t entry,
  output logic       pop,
  output logic       row_valid,
  input  logic       row_ready,
  output row_item_t  row_item
);

`include "triangle_element_stiffness_core_defines.svh"

  back_state_t state, state_next;
  tri_entry_t  cur;
  logic [1:0]  row, col;
  logic        deg;
  logic signed [PROD_W-1:0] prod, acc;
  logic signed [DEN_W-1:0]  twod;
  logic signed [DET_W-1:0]  det;
  logic signed [OP_W-1:0]   mul_a, mul_b;
  logic mul_en, acc_en, out_load;
  logic [3:0][RES_W-1:0] res;
  logic signed [DET_W-1:0]  dot;
  logic signed [NUM_W-1:0]  num;
  div_req_t    req;
  logic        div_done;
  logic [RES_W-1:0] quo;
  logic        last_row;

  tesc_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .done (div_done),
    .quo  (quo)
  );

  assign det = DET_W'(acc) - DET_W'(prod);

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE:    if (avail) state_next = B_DET0;
      B_DET0:    state_next = B_DET1;
      B_DET1:    state_next = B_DETCHK;
      B_DETCHK:  state_next = (det == '0) ? B_EMIT : B_SEL;
      B_SEL: begin
        if (row == NO_ROW) state_next = B_IDLE;
        else if (cur.emit[row]) state_next = B_MULP;
      end
      B_MULP:    state_next = B_MULQ;
      B_MULQ:    state_next = B_DIVGO;
      B_DIVGO:   state_next = B_DIVWAIT;
      B_DIVWAIT: if (div_done) state_next = (col == LOAD_COL) ? B_EMIT : B_MULP;
      B_EMIT:    if (out_load) state_next = deg ? B_IDLE : B_SEL;
      default:   state_next = B_IDLE;
    endcase
  end

  always_comb begin
    pop      = (state == B_IDLE) && avail;
    mul_en   = 1'b0;
    acc_en   = 1'b0;
    mul_a    = '0;
    mul_b    = '0;
    out_load = (state == B_EMIT) && (!row_valid || row_ready);
    case (state)
      B_DET0: begin
        mul_en = 1'b1;
        mul_a  = cur.p[1];
        mul_b  = cur.q[2];
      end
      B_DET1: begin
        mul_en = 1'b1;
        acc_en = 1'b1;
        mul_a  = cur.p[2];
        mul_b  = cur.q[1];
      end
      B_MULP: begin
        mul_en = 1'b1;
        mul_a  = cur.p[row];
        mul_b  = (col == LOAD_COL) ? cur.sy : cur.p[col];
      end
      B_MULQ: begin
        mul_en = 1'b1;
        acc_en = 1'b1;
        mul_a  = cur.q[row];
        mul_b  = (col == LOAD_COL) ? cur.sx : cur.q[col];
      end
      default: ;
    endcase
  end

  always_comb begin
    dot = DET_W'(acc) + DET_W'(prod);
    if (col == LOAD_COL) begin
      num         = NUM_W'(det);
      req.den_mag = '0;
      req.neg     = num[NUM_W-1];
      req.by6     = 1'b1;
    end else begin
      num         = {dot, {FRAC_W{1'b0}}};
      req.den_mag = twod[DEN_W-1] ? DEN_W'(-twod) : DEN_W'(twod);
      req.neg     = num[NUM_W-1] ^ twod[DEN_W-1];
      req.by6     = 1'b0;
    end
    req.num_mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    req.start   = (state == B_DIVGO);
    case (row)
      2'd0:    last_row = !(cur.emit[1] || cur.emit[2]);
      2'd1:    last_row = !cur.emit[2];
      default: last_row = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      row_valid <= 1'b0;
      row       <= '0;
      col       <= '0;
      deg       <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) row_valid <= 1'b1;
      else if (row_ready) row_valid <= 1'b0;
      if (state == B_DETCHK) begin
        row <= '0;
        deg <= (det == '0);
      end
      if (state == B_SEL && row != NO_ROW) begin
        if (cur.emit[row]) col <= '0;
        else row <= row + 1'b1;
      end
      if (state == B_DIVWAIT && div_done) col <= col + 1'b1;
      if (out_load && !deg) row <= row + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) cur <= entry;
    if (mul_en) prod <= mul_a * mul_b;
    if (acc_en) acc <= prod;
    if (state == B_DETCHK) twod <= {det, 1'b0};
    if (state == B_DIVWAIT && div_done) res[col] <= quo;
    if (out_load) begin
      if (deg) begin
        row_item <= '{row_node: '0, entry_col_a: '0, entry_col_b: '0, entry_col_c: '0,
                      load_part: '0, degenerate: 1'b1, last: 1'b1};
      end else begin
        row_item.row_node    <= cur.node[row];
        row_item.entry_col_a <= res[0];
        row_item.entry_col_b <= res[1];
        row_item.entry_col_c <= res[2];
        row_item.load_part   <= res[LOAD_COL];
        row_item.degenerate  <= 1'b0;
        row_item.last        <= last_row;
      end
    end
  end

  `TESC_ASSERT(a_deg_last, row_valid && row_item.degenerate, row_item.last && row_item.row_node == '0)
  `TESC_ASSERT(a_row_node, row_valid && !row_item.degenerate, row_item.row_node != '0)
  `TESC_ASSERT(a_div_state, div_done, state == B_DIVWAIT)
  `TESC_ASSERT_NEXT(a_row_hold, row_valid && !row_ready, row_valid)

endmodule

>>> tb/sv/triangle_element_stiffness_core_test.sv
`timescale 1ns / 100ps

module triangle_element_stiffness_core_test;
  import tesc_pkg::*;

  typedef logic signed [127:0] wide_t;

  class row_scoreboard;
    row_item_t rows_due[$];
    int        faults;

    function wide_t widen(longint v);
      wide_t w;
      w = v;
      return w;
    endfunction

    function logic signed [63:0] div_sat(wide_t n, wide_t d);
      wide_t r;
      r = n / d;
      if (r > widen(64'sh7FFF_FFFF_FFFF_FFFF)) return 64'sh7FFF_FFFF_FFFF_FFFF;
      if (r < widen(-64'sh7FFF_FFFF_FFFF_FFFF - 1)) return 64'sh8000_0000_0000_0000;
      return r[63:0];
    endfunction

    function void note_triangle(tri_item_t t);
      longint xa, ya, xb, yb, xc, yc, dx1, dy1, dx2, dy2, sx, sy;
      longint p[3], q[3];
      logic [15:0] nd[3];
      wide_t det, twod, dot;
      row_item_t r;
      int k, j, first;
      xa = t.x_a; ya = t.y_a; xb = t.x_b; yb = t.y_b; xc = t.x_c; yc = t.y_c;
      dx1 = xb - xa; dy1 = yb - ya; dx2 = xc - xa; dy2 = yc - ya;
      sx = xa + xb + xc; sy = ya + yb + yc;
      nd[0] = t.node_a; nd[1] = t.node_b; nd[2] = t.node_c;
      det = widen(dx1) * widen(dy2) - widen(dy1) * widen(dx2);
      if (det == 0) begin
        r = '0;
        r.degenerate = 1'b1;
        r.last = 1'b1;
        rows_due = {rows_due, r};
        return;
      end
      p[0] = yb - yc; q[0] = xc - xb;
      p[1] = dy2;     q[1] = -dx2;
      p[2] = -dy1;    q[2] = dx1;
      twod = det + det;
      first = rows_due.size();
      for (k = 0; k < 3; k++) begin
        if (nd[k] == 0) continue;
        r = '0;
        r.row_node = nd[k];
        for (j = 0; j < 3; j++) begin
          dot = widen(p[k]) * widen(p[j]) + widen(q[k]) * widen(q[j]);
          case (j)
            0: r.entry_col_a = div_sat(dot <<< 32, twod);
            1: r.entry_col_b = div_sat(dot <<< 32, twod);
            default: r.entry_col_c = div_sat(dot <<< 32, twod);
          endcase
        end
        r.load_part = div_sat(widen(p[k]) * widen(sy) - widen(q[k]) * widen(sx), widen(6));
        rows_due = {rows_due, r};
      end
      if (rows_due.size() > first) rows_due[rows_due.size() - 1].last = 1'b1;
    endfunction

    function void cmp(string name, logic [63:0] e, logic [63:0] a);
      if (e !== a) begin
        $error("%s: expected %h, got %h", name, e, a);
        faults++;
      end
    endfunction

    function void check_row(row_item_t a);
      row_item_t e;
      if (rows_due.size() == 0) begin
        $error("row beat with nothing due: %p", a);
        faults++;
        return;
      end
      e = rows_due.pop_front();
      cmp("row_node", e.row_node, a.row_node);
      cmp("entry_col_a", e.entry_col_a, a.entry_col_a);
      cmp("entry_col_b", e.entry_col_b, a.entry_col_b);
      cmp("entry_col_c", e.entry_col_c, a.entry_col_c);
      cmp("load_part", e.load_part, a.load_part);
      cmp("degenerate", e.degenerate, a.degenerate);
      cmp("last", e.last, a.last);
    endfunction
  endclass

  logic clk, rst, tri_valid, tri_ready, row_valid, row_ready;
  tri_item_t tri_item;
  row_item_t row_item;
  row_scoreboard sb;
  int stall_mode, stall_left;

  triangle_element_stiffness_core dut (
    .clk(clk), .rst(rst),
    .tri_valid(tri_valid), .tri_ready(tri_ready), .tri_item(tri_item),
    .row_valid(row_valid), .row_ready(row_ready), .row_item(row_item)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (row_valid && row_ready) sb.check_row(row_item);
      if (stall_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        stall_left <= $urandom_range(5, 400);
      end else begin
        stall_left <= stall_left - 1;
      end
      case (stall_mode)
        0: row_ready <= 1'b1;
        1: row_ready <= ($urandom_range(0, 3) != 0);
        2: row_ready <= ($urandom_range(0, 3) == 0);
        default: row_ready <= (stall_left[2:0] == 0);
      endcase
    end
  end

  task automatic send_tri(tri_item_t t, int gap);
    tri_valid <= 1'b1;
    tri_item <= t;
    do @(posedge clk); while (!tri_ready);
    sb.note_triangle(t);
    if (gap > 0) begin
      tri_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic [15:0] pick_node();
    if ($urandom_range(0, 4) == 0) return 16'd0;
    if ($urandom_range(0, 9) == 0) return 16'hFFFF;
    return 16'($urandom_range(1, 65535));
  endfunction

  function automatic tri_item_t rand_tri();
    tri_item_t t;
    int m, k;
    t.node_a = pick_node(); t.node_b = pick_node(); t.node_c = pick_node();
    m = $urandom_range(0, 9);
    t.x_a = $urandom; t.y_a = $urandom; t.x_b = $urandom;
    t.y_b = $urandom; t.x_c = $urandom; t.y_c = $urandom;
    if (m < 5) begin
      t.x_a = t.x_a >>> 11; t.y_a = t.y_a >>> 11; t.x_b = t.x_b >>> 11;
      t.y_b = t.y_b >>> 11; t.x_c = t.x_c >>> 11; t.y_c = t.y_c >>> 11;
    end else if (m == 7) begin
      k = $urandom_range(0, 5) - 2;
      t.x_a = t.x_a >>> 14; t.y_a = t.y_a >>> 14;
      t.x_b = t.x_b >>> 14; t.y_b = t.y_b >>> 14;
      t.x_c = t.x_a + k * (t.x_b - t.x_a);
      t.y_c = t.y_a + k * (t.y_b - t.y_a);
    end else if (m == 8) begin
      t.x_c = t.x_b; t.y_c = t.y_b;
    end
    return t;
  endfunction

  function automatic tri_item_t mk(int xa, int ya, int xb, int yb, int xc, int yc,
                                   int na, int nb, int nc);
    tri_item_t t;
    t.x_a = xa; t.y_a = ya; t.x_b = xb; t.y_b = yb; t.x_c = xc; t.y_c = yc;
    t.node_a = 16'(na); t.node_b = 16'(nb); t.node_c = 16'(nc);
    return t;
  endfunction

  localparam int MAXI = 32'h7FFF_FFFF;
  localparam int MINI = 32'h8000_0000;

  initial begin
    tri_item_t dir[$];
    clk = 0; rst = 1; tri_valid = 0; tri_item = '0; row_ready = 0;
    stall_mode = 0; stall_left = 0;
    sb = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    dir = {dir, mk(0, 0, 32'h10000, 0, 0, 32'h10000, 1, 2, 3)};
    dir = {dir, mk(0, 0, 0, 32'h10000, 32'h10000, 0, 1, 2, 3)};
    dir = {dir, mk(MINI, MINI, MAXI, MINI, MINI, MAXI, 65535, 65535, 65535)};
    dir = {dir, mk(MAXI, MAXI, MINI, MAXI, MAXI, MINI, 7, 8, 9)};
    dir = {dir, mk(0, 0, 1, 0, MAXI, 1, 4, 5, 6)};
    dir = {dir, mk(0, 0, MAXI, 1, 1, 0, 4, 5, 6)};
    dir = {dir, mk(MINI, 0, MAXI, 1, MAXI, 0, 1, 1, 1)};
    dir = {dir, mk(0, 0, 32'h10000, 0, 0, 32'h10000, 0, 2, 3)};
    dir = {dir, mk(0, 0, 32'h10000, 0, 0, 32'h10000, 1, 0, 3)};
    dir = {dir, mk(0, 0, 32'h10000, 0, 0, 32'h10000, 1, 2, 0)};
    dir = {dir, mk(0, 0, 32'h10000, 0, 0, 32'h10000, 0, 0, 0)};
    dir = {dir, mk(5, 5, 5, 5, 5, 5, 1, 2, 3)};
    dir = {dir, mk(0, 0, 1, 1, 2, 2, 0, 0, 0)};
    dir = {dir, mk(MINI, MINI, MAXI, MAXI, MINI, MINI, 9, 10, 11)};
    dir = {dir, mk(MAXI, MINI, MINI, MAXI, 0, -1, 65535, 1, 0)};
    dir = {dir, mk(-32'h30000, 32'h20000, 32'h50000, -32'h10000, 32'h8000, 32'h70000,
                   100, 200, 300)};
    foreach (dir[i]) send_tri(dir[i], (i % 3 == 0) ? 0 : $urandom_range(0, 5));

    for (int n = 0; n < 350; n++) begin
      if (n == 120) begin
        tri_valid <= 1'b0;
        while (sb.rows_due.size() != 0) @(posedge clk);
      end
      send_tri(rand_tri(), ($urandom_range(0, 3) == 0) ? $urandom_range(1, 1500) : 0);
    end
    tri_valid <= 1'b0;

    while (sb.rows_due.size() != 0) @(posedge clk);
    repeat (1500) @(posedge clk);
    if (sb.faults == 0) begin
      $display("triangle_element_stiffness_core regression: pass");
    end else begin
      $display("triangle_element_stiffness_core regression: fail");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("triangle_element_stiffness_core regression: fail");
    $finish;
  end

endmodule
